@@ rtl/histogram_filter_localizer_core_assert.svh @@
// ----------------------------------------------------------------------------
// Histogram filter localizer: assertion macros
// Shared immediate-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_FILTER_LOCALIZER_CORE_ASSERT_SVH
`define HISTOGRAM_FILTER_LOCALIZER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HFL_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hfl assertion failed");

// antecedent implies consequent in the next cycle
`define HFL_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hfl assertion failed");

`endif

@@ rtl/hfl_pkg.sv @@
// ----------------------------------------------------------------------------
// Histogram filter localizer: package
// Sizes, codes, control structs and constant tables shared by the block.
// ----------------------------------------------------------------------------
package hfl_pkg;

   localparam int MAX_CELLS   = 16;
   localparam int CELL_CAP    = (MAX_CELLS < 16) ? MAX_CELLS : 16;
   localparam int CIDX_W      = $clog2(CELL_CAP);
   localparam int CNT_W       = $clog2(CELL_CAP + 1);
   localparam int PROB_W      = 16;
   localparam int PROD_W      = 2 * PROB_W;
   localparam int ACC_W       = PROD_W + (($clog2(CELL_CAP) > 2) ? $clog2(CELL_CAP) : 2);
   localparam int STEP_W      = $clog2(PROB_W);
   localparam int RESET_CELLS = (CELL_CAP < 5) ? CELL_CAP : 5;

   // item op codes
   localparam logic [1:0] OP_SENSE   = 2'd0;
   localparam logic [1:0] OP_MOVE    = 2'd1;
   localparam logic [1:0] OP_UNIFORM = 2'd2;

   // csr register indexes
   localparam logic [2:0] CSR_HIT_GAIN   = 3'd0;
   localparam logic [2:0] CSR_MISS_GAIN  = 3'd1;
   localparam logic [2:0] CSR_EXACT      = 3'd2;
   localparam logic [2:0] CSR_OVERSHOOT  = 3'd3;
   localparam logic [2:0] CSR_UNDERSHOOT = 3'd4;
   localparam logic [2:0] CSR_WORLD_MAP  = 3'd5;
   localparam logic [2:0] CSR_CELLS      = 3'd6;

   typedef struct packed {
      logic mul_en;
      logic acc_clr;
      logic acc_add;
      logic div_load;
      logic div_step;
   } unit_ctl_type;

   typedef struct packed {
      logic              acc_zero;
      logic [PROB_W-1:0] div_q;   // saturated quotient
      logic [PROB_W-1:0] mac_q;   // saturated acc >> 16
   } unit_stat_type;

   typedef struct packed {
      logic              en;
      logic [CIDX_W-1:0] idx;
      logic [PROB_W-1:0] data;
   } bel_wr_type;

   // floor(65536 / n) saturated to 16 bits
   function automatic logic [PROB_W-1:0] uniform_prob(input logic [4:0] n);
      logic [PROB_W-1:0] p;
      case (n)
         5'd2:    p = 16'd32768;
         5'd3:    p = 16'd21845;
         5'd4:    p = 16'd16384;
         5'd5:    p = 16'd13107;
         5'd6:    p = 16'd10922;
         5'd7:    p = 16'd9362;
         5'd8:    p = 16'd8192;
         5'd9:    p = 16'd7281;
         5'd10:   p = 16'd6553;
         5'd11:   p = 16'd5957;
         5'd12:   p = 16'd5461;
         5'd13:   p = 16'd5041;
         5'd14:   p = 16'd4681;
         5'd15:   p = 16'd4369;
         5'd16:   p = 16'd4096;
         default: p = 16'd65535;
      endcase
      return p;
   endfunction

   function automatic logic [PROB_W-1:0] reset_belief(input int idx);
      return (idx < RESET_CELLS) ? uniform_prob(5'(RESET_CELLS)) : '0;
   endfunction

endpackage

@@ rtl/hfl_belief.sv @@
// ----------------------------------------------------------------------------
// Histogram filter localizer: belief store
// Belief cells with reset to the uniform start value, plus a scratch row.
// ----------------------------------------------------------------------------
module hfl_belief import hfl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  bel_wr_type        bel_wr,
   input  bel_wr_type        scr_wr,
   input  logic [CIDX_W-1:0] rd_idx,
   output logic [PROB_W-1:0] bel_rd_data,
   output logic [PROB_W-1:0] scr_rd_data
);

   logic [PROB_W-1:0] belief_ff  [CELL_CAP];
   logic [PROB_W-1:0] scratch_ff [CELL_CAP];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELL_CAP; i++) begin
            belief_ff[i] <= reset_belief(i);
         end
      end else if (bel_wr.en) begin
         belief_ff[bel_wr.idx] <= bel_wr.data;
      end
   end

   // scratch is always written before read
   always_ff @(posedge clock) begin
      if (scr_wr.en) begin
         scratch_ff[scr_wr.idx] <= scr_wr.data;
      end
   end

   assign bel_rd_data = belief_ff[rd_idx];
   assign scr_rd_data = scratch_ff[rd_idx];

endmodule

@@ rtl/hfl_unit.sv @@
// ----------------------------------------------------------------------------
// Histogram filter localizer: shared arithmetic unit
// 16x16 multiplier, accumulator and one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module hfl_unit import hfl_pkg::*; (
   input  logic              clock,
   input  unit_ctl_type      ctl,
   input  logic [PROB_W-1:0] mul_a,
   input  logic [PROB_W-1:0] mul_b,
   output unit_stat_type     stat
);

   logic [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  rem_ff;
   logic [PROB_W:0]   quo_ff;

   logic [ACC_W:0]    div_x;
   logic [ACC_W:0]    div_d;
   logic              div_ge;
   logic [ACC_W-1:0]  rem_in;

   // divisor is the accumulated sum; load starts on the product (weight 2^16 bit)
   always_comb begin
      div_x  = ctl.div_load ? (ACC_W+1)'(prod_ff) : {rem_ff, 1'b0};
      div_d  = {1'b0, acc_ff};
      div_ge = (div_x >= div_d);
      rem_in = div_ge ? ACC_W'(div_x - div_d) : ACC_W'(div_x);
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      if (ctl.acc_clr) begin
         acc_ff <= '0;
      end else if (ctl.acc_add) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (ctl.div_load) begin
         rem_ff <= rem_in;
         quo_ff <= {{PROB_W{1'b0}}, div_ge};
      end else if (ctl.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[PROB_W-1:0], div_ge};
      end
   end

   assign stat.acc_zero = (acc_ff == '0);
   assign stat.div_q    = quo_ff[PROB_W] ? '1 : quo_ff[PROB_W-1:0];
   assign stat.mac_q    = (|acc_ff[ACC_W-1:PROD_W]) ? '1 : acc_ff[PROD_W-1:PROB_W];

endmodule

@@ rtl/histogram_filter_localizer_core.sv @@
// ----------------------------------------------------------------------------
// Histogram filter localizer core
// Discrete Bayes filter over a cyclic 1-D world of up to 16 cells, Q0.16 belief.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  req     | in  | req_tvalid/tready  | tdata: op, measured_color, shift
//  rsp     | out | rsp_tvalid/tready  | tdata: cell_index, probability;
//          |     |                    | tuser: sum_zero; tlast: last cell
//  csr     | in  | csr_we             | csr_addr register index, csr_wdata value
//
//  Op 3 returns nothing. Sense and move run on the single shared multiplier
//  (one product per cycle while enabled); sense then normalizes with the
//  restoring divider, one quotient bit per cycle, 17 bits per cell.
//  req_tready is high only while idle; an item is taken even when the last
//  result of the previous one still waits in the output register.
//  A stalled rsp side holds the emit walk; no results are dropped.
//  Reset is synchronous: control and config registers get their defaults, belief is uniform over 5.
//
module histogram_filter_localizer_core import hfl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] op, [3:2] measured_color, [7:4] shift
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] cell_index, [19:4] probability, rest 0
   output logic        rsp_tuser,   // [0] sum_zero
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

`include "histogram_filter_localizer_core_assert.svh"

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MOD    = 4'd1;   // shift mod n
   localparam logic [3:0] ST_MUL    = 4'd2;
   localparam logic [3:0] ST_ACC    = 4'd3;
   localparam logic [3:0] ST_CHK    = 4'd4;   // zero-sum test
   localparam logic [3:0] ST_DMUL   = 4'd5;
   localparam logic [3:0] ST_DLOAD  = 4'd6;
   localparam logic [3:0] ST_DSTEP  = 4'd7;
   localparam logic [3:0] ST_DSTORE = 4'd8;
   localparam logic [3:0] ST_MWR    = 4'd9;
   localparam logic [3:0] ST_EMIT   = 4'd10;

   // move taps
   localparam logic [1:0] TAP_EXACT = 2'd0;
   localparam logic [1:0] TAP_OVER  = 2'd1;
   localparam logic [1:0] TAP_UNDER = 2'd2;

   // emit source
   localparam logic [1:0] SRC_BELIEF  = 2'd0;
   localparam logic [1:0] SRC_SCRATCH = 2'd1;
   localparam logic [1:0] SRC_UNIFORM = 2'd2;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROB_W - 1);

   // ---------------- configuration registers ----------------
   logic [15:0] hit_gain_ff, miss_gain_ff, exact_ff, over_ff, under_ff;
   logic [31:0] world_map_ff;
   logic [4:0]  cells_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_gain_ff  <= 16'd39322;
         miss_gain_ff <= 16'd13107;
         exact_ff     <= 16'd52429;
         over_ff      <= 16'd6554;
         under_ff     <= 16'd6554;
         world_map_ff <= '0;
         cells_ff     <= 5'd5;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_HIT_GAIN:   hit_gain_ff  <= csr_wdata[15:0];
            CSR_MISS_GAIN:  miss_gain_ff <= csr_wdata[15:0];
            CSR_EXACT:      exact_ff     <= csr_wdata[15:0];
            CSR_OVERSHOOT:  over_ff      <= csr_wdata[15:0];
            CSR_UNDERSHOOT: under_ff     <= csr_wdata[15:0];
            CSR_WORLD_MAP:  world_map_ff <= csr_wdata;
            CSR_CELLS:      cells_ff     <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // clamp cell count to 1..CELL_CAP
   logic [CNT_W-1:0] n_now;
   always_comb begin
      if (cells_ff == 5'd0) begin
         n_now = CNT_W'(1);
      end else if (cells_ff > 5'(CELL_CAP)) begin
         n_now = CNT_W'(CELL_CAP);
      end else begin
         n_now = CNT_W'(cells_ff);
      end
   end

   // ---------------- sequencer registers ----------------
   logic [3:0]        state_ff, state_in;
   logic [1:0]        op_ff;
   logic [1:0]        color_ff;
   logic [3:0]        u_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CIDX_W-1:0] idx_ff;
   logic [1:0]        tap_ff;
   logic [STEP_W-1:0] step_ff;
   logic [1:0]        src_ff;
   logic              flag_ff;

   logic        rsp_valid_ff;
   logic [3:0]  rsp_cell_ff;
   logic [15:0] rsp_prob_ff;
   logic        rsp_flag_ff;
   logic        rsp_last_ff;

   logic [1:0] req_op;
   logic [1:0] req_color;
   logic [3:0] req_shift;
   logic       req_fire;

   assign req_op     = req_tdata[1:0];
   assign req_color  = req_tdata[3:2];
   assign req_shift  = req_tdata[7:4];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   logic [CIDX_W-1:0] last_idx;
   logic              idx_last;
   logic              u_ge_n;
   logic              emit_load;

   assign last_idx  = CIDX_W'(n_ff - 1'b1);
   assign idx_last  = (idx_ff == last_idx);
   assign u_ge_n    = (5'(u_ff) >= 5'(n_ff));
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // move source cells: a = (i - u) mod n, o = a - 1, b = a + 1 (cyclic)
   logic [CNT_W:0]    mv_base;
   logic [CIDX_W-1:0] a_idx, o_idx, b_idx;
   always_comb begin
      mv_base = (CNT_W+1)'(idx_ff) + (CNT_W+1)'(n_ff) - (CNT_W+1)'(u_ff);
      if (mv_base >= (CNT_W+1)'(n_ff)) begin
         a_idx = CIDX_W'(mv_base - (CNT_W+1)'(n_ff));
      end else begin
         a_idx = CIDX_W'(mv_base);
      end
      o_idx = (a_idx == '0) ? last_idx : a_idx - 1'b1;
      b_idx = (a_idx == last_idx) ? '0 : a_idx + 1'b1;
   end

   // ---------------- belief store and shared unit ----------------
   logic [CIDX_W-1:0] rd_idx;
   logic [PROB_W-1:0] bel_rd_data, scr_rd_data;
   bel_wr_type        bel_wr, scr_wr;
   unit_ctl_type      unit_ctl;
   unit_stat_type     unit_stat;
   logic [PROB_W-1:0] mul_a;
   logic [PROB_W-1:0] emit_data;
   logic [1:0]        cell_color;

   assign cell_color = world_map_ff[{idx_ff, 1'b0} +: 2];

   always_comb begin
      rd_idx = idx_ff;
      if (state_ff == ST_MUL && op_ff == OP_MOVE) begin
         case (tap_ff)
            TAP_EXACT: rd_idx = a_idx;
            TAP_OVER:  rd_idx = o_idx;
            default:   rd_idx = b_idx;
         endcase
      end
   end

   always_comb begin
      if (op_ff == OP_MOVE) begin
         case (tap_ff)
            TAP_EXACT: mul_a = exact_ff;
            TAP_OVER:  mul_a = over_ff;
            default:   mul_a = under_ff;
         endcase
      end else begin
         mul_a = (cell_color == color_ff) ? hit_gain_ff : miss_gain_ff;
      end
   end

   always_comb begin
      unit_ctl          = '0;
      unit_ctl.mul_en   = (state_ff == ST_MUL) || (state_ff == ST_DMUL);
      unit_ctl.acc_clr  = (req_fire && req_op == OP_SENSE) ||
                          (state_ff == ST_MUL && op_ff == OP_MOVE && tap_ff == TAP_EXACT);
      unit_ctl.acc_add  = (state_ff == ST_ACC);
      unit_ctl.div_load = (state_ff == ST_DLOAD);
      unit_ctl.div_step = (state_ff == ST_DSTEP);
   end

   always_comb begin
      case (src_ff)
         SRC_BELIEF:  emit_data = bel_rd_data;
         SRC_SCRATCH: emit_data = scr_rd_data;
         default:     emit_data = uniform_prob(5'(n_ff));
      endcase
   end

   always_comb begin
      scr_wr.en   = (state_ff == ST_DSTORE) || (state_ff == ST_MWR);
      scr_wr.idx  = idx_ff;
      scr_wr.data = (state_ff == ST_DSTORE) ? unit_stat.div_q : unit_stat.mac_q;
      // commit new belief as each cell goes out
      bel_wr.en   = emit_load && (src_ff != SRC_BELIEF);
      bel_wr.idx  = idx_ff;
      bel_wr.data = emit_data;
   end

   hfl_belief u_belief (
      .clock       (clock),
      .reset       (reset),
      .bel_wr      (bel_wr),
      .scr_wr      (scr_wr),
      .rd_idx      (rd_idx),
      .bel_rd_data (bel_rd_data),
      .scr_rd_data (scr_rd_data)
   );

   hfl_unit u_unit (
      .clock (clock),
      .ctl   (unit_ctl),
      .mul_a (mul_a),
      .mul_b (bel_rd_data),
      .stat  (unit_stat)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_SENSE:   state_in = ST_MUL;
                  OP_MOVE:    state_in = ST_MOD;
                  OP_UNIFORM: state_in = ST_EMIT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_MOD:    state_in = u_ge_n ? ST_MOD : ST_MUL;
         ST_MUL:    state_in = ST_ACC;
         ST_ACC: begin
            if (op_ff == OP_MOVE) begin
               state_in = (tap_ff == TAP_UNDER) ? ST_MWR : ST_MUL;
            end else begin
               state_in = idx_last ? ST_CHK : ST_MUL;
            end
         end
         ST_CHK:    state_in = unit_stat.acc_zero ? ST_EMIT : ST_DMUL;
         ST_DMUL:   state_in = ST_DLOAD;
         ST_DLOAD:  state_in = ST_DSTEP;
         ST_DSTEP:  state_in = (step_ff == STEP_LAST) ? ST_DSTORE : ST_DSTEP;
         ST_DSTORE: state_in = idx_last ? ST_EMIT : ST_DMUL;
         ST_MWR:    state_in = idx_last ? ST_EMIT : ST_MUL;
         ST_EMIT:   state_in = (emit_load && idx_last) ? ST_IDLE : ST_EMIT;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_SENSE;
         color_ff <= '0;
         u_ff     <= '0;
         n_ff     <= CNT_W'(1);
         idx_ff   <= '0;
         tap_ff   <= TAP_EXACT;
         step_ff  <= '0;
         src_ff   <= SRC_BELIEF;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_op;
                  color_ff <= req_color;
                  u_ff     <= req_shift;
                  n_ff     <= n_now;
                  idx_ff   <= '0;
                  tap_ff   <= TAP_EXACT;
                  flag_ff  <= 1'b0;
                  src_ff   <= (req_op == OP_UNIFORM) ? SRC_UNIFORM : SRC_SCRATCH;
               end
            end
            ST_MOD: begin
               if (u_ge_n) begin
                  u_ff <= u_ff - 4'(n_ff);
               end
            end
            ST_ACC: begin
               if (op_ff == OP_MOVE) begin
                  tap_ff <= (tap_ff == TAP_UNDER) ? TAP_EXACT : tap_ff + 1'b1;
               end else if (!idx_last) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_CHK: begin
               idx_ff <= '0;
               if (unit_stat.acc_zero) begin
                  // zero sum: emit the belief as it stands
                  flag_ff <= 1'b1;
                  src_ff  <= SRC_BELIEF;
               end
            end
            ST_DLOAD:  step_ff <= '0;
            ST_DSTEP:  step_ff <= step_ff + 1'b1;
            ST_DSTORE, ST_MWR: begin
               idx_ff <= idx_last ? '0 : idx_ff + 1'b1;
            end
            ST_EMIT: begin
               if (emit_load) begin
                  idx_ff <= idx_last ? '0 : idx_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_cell_ff <= 4'(idx_ff);
         rsp_prob_ff <= emit_data;
         rsp_flag_ff <= flag_ff;
         rsp_last_ff <= idx_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_prob_ff, rsp_cell_ff};
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   `HFL_ASSERT_IMPL(a_emit_idx_in_range, state_ff == ST_EMIT, CNT_W'(idx_ff) < n_ff)
   `HFL_ASSERT_IMPL(a_div_nonzero_sum, state_ff == ST_DSTORE, !unit_stat.acc_zero)
   `HFL_ASSERT_IMPL(a_flag_only_sense, flag_ff, op_ff == OP_SENSE)
   `HFL_ASSERT_NEXT(a_last_emit_idles, emit_load && idx_last, state_ff == ST_IDLE)

endmodule
